/* rtl/grwi_pkg.sv */
// ----------------------------------------------------------------------------
// grwi_pkg
// Shared constants, codes and the quarter-wave sine table of the ray caster.
// ----------------------------------------------------------------------------
package grwi_pkg;

    localparam int MAP_COLUMNS = 32;
    localparam int MAP_LINES   = 16;
    localparam int COL_W       = 5;
    localparam int ROW_W       = 4;
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int MAP_DEPTH   = MAP_LINES * MAP_COLUMNS;

    // One tile is 64 pixels, 2^14 in Q.8.
    localparam int TILE_SHIFT  = 14;
    localparam int TILE_Q8     = 1 << TILE_SHIFT;

    localparam int POS_W       = 36;
    localparam int MUL_W       = 29;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int NUM_W       = 31;
    localparam int DEN_W       = 16;
    localparam int QUOT_W      = 30;
    localparam int CNT_W       = 6;

    localparam logic [23:0] QUARTER_TURN = 24'h40_0000;
    localparam int          MIN_TRIG     = 4;

    localparam logic [2:0] CFG_PLAYER_X   = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y   = 3'd1;
    localparam logic [2:0] CFG_VIEW_ANGLE = 3'd2;
    localparam logic [2:0] CFG_HALF_FOV   = 3'd3;
    localparam logic [2:0] CFG_ANGLE_STEP = 3'd4;

    localparam logic ACT_WRITE_CELL = 1'b0;
    localparam logic ACT_CAST       = 1'b1;

    function automatic logic [15:0] sine_rom(input logic [4:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3212;
            5'd2:    v = 16'd6393;
            5'd3:    v = 16'd9512;
            5'd4:    v = 16'd12540;
            5'd5:    v = 16'd15447;
            5'd6:    v = 16'd18205;
            5'd7:    v = 16'd20788;
            5'd8:    v = 16'd23170;
            5'd9:    v = 16'd25330;
            5'd10:   v = 16'd27246;
            5'd11:   v = 16'd28899;
            5'd12:   v = 16'd30274;
            5'd13:   v = 16'd31357;
            5'd14:   v = 16'd32138;
            5'd15:   v = 16'd32610;
            default: v = 16'd32767;
        endcase
        return v;
    endfunction

endpackage

/* rtl/grwi_ram.sv */
// ----------------------------------------------------------------------------
// grwi_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module grwi_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

/* rtl/grwi_div.sv */
// ----------------------------------------------------------------------------
// grwi_div
// Signed divider, rounding to nearest with ties away from zero, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module grwi_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [grwi_pkg::NUM_W-1:0]   i_num,
    input  logic signed [grwi_pkg::DEN_W-1:0]   i_den,
    output logic                                o_done,
    output logic signed [grwi_pkg::QUOT_W-1:0]  o_quot
);

    localparam int NW = grwi_pkg::NUM_W;
    localparam int DW = grwi_pkg::DEN_W;

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [4:0]    r_cnt;
    logic [NW-1:0] r_dvd;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [NW-1:0] abs_num;
    logic [DW-1:0] abs_den;
    logic [DW:0]   trial;
    logic          fits;

    assign abs_num = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
    assign abs_den = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign trial   = {r_rem, r_dvd[NW-1]};
    assign fits    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= abs_den;
                r_neg  <= i_num[NW-1] ^ i_den[DW-1];
                // Adding half the divisor turns the truncating quotient into
                // a rounded one.
                r_dvd  <= abs_num + NW'(abs_den >> 1);
            end else if (r_busy) begin
                r_rem <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                r_dvd <= {r_dvd[NW-2:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_dvd[grwi_pkg::QUOT_W-1:0])
                          : $signed(r_dvd[grwi_pkg::QUOT_W-1:0]);

endmodule

/* rtl/grid_ray_wall_intersect.sv */
// ----------------------------------------------------------------------------
// grid_ray_wall_intersect
// Tile-map ray caster: finds the nearer wall crossing of one ray.
// ----------------------------------------------------------------------------
// The input channel (i_valid / o_ready) carries one item per handshake: a
// map-cell write (action 0) or a ray cast (action 1). A cell write goes to the
// map RAM and gives no result. A cast gives one result item on the output
// channel (o_valid / i_ready). The configuration channel (i_cfg_valid /
// o_cfg_ready) is always ready and writes the viewer position and the angle
// registers; write it only while the block is idle.
// A cast runs through one shared multiplier, a shared one-bit-per-cycle
// divider (two divides per walk, up to four per ray) and a walk that reads
// the map RAM once per grid crossing, up to 18 horizontal and 34 vertical
// crossings. The walk lengths, a skipped walk and the serial divider set how
// long a cast takes from acceptance to a valid result.
// After reset the block clears the 512-cell map RAM, one cell per cycle, and
// holds o_ready low until the clear is done. A finished result waits in the
// output register; the block takes the next item meanwhile, and a new result
// waits in its last state until the receiver takes the old one.
// ----------------------------------------------------------------------------
module grid_ray_wall_intersect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [3:0]          i_cell_row,
    input  logic [4:0]          i_cell_col,
    input  logic                i_cell_wall,
    input  logic [9:0]          i_ray_column,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [9:0]          o_ray_column_out,
    output logic signed [19:0]  o_hit_x,
    output logic signed [19:0]  o_hit_y,
    output logic [31:0]         o_sq_distance,
    output logic                o_vertical_hit,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    localparam int PW = grwi_pkg::POS_W;
    localparam int MW = grwi_pkg::MUL_W;
    localparam int AW = grwi_pkg::ADDR_W;
    localparam int CW = grwi_pkg::CNT_W;
    localparam int TS = grwi_pkg::TILE_SHIFT;
    localparam int PROD_W_T = grwi_pkg::PROD_W;
    localparam int QUOT_W_T = grwi_pkg::QUOT_W;

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_ANG_MUL  = 5'd2;
    localparam logic [4:0] S_ANG      = 5'd3;
    localparam logic [4:0] S_SIN_MUL  = 5'd4;
    localparam logic [4:0] S_SIN_FIN  = 5'd5;
    localparam logic [4:0] S_PH_START = 5'd6;
    localparam logic [4:0] S_PH_MUL   = 5'd7;
    localparam logic [4:0] S_DIV0     = 5'd8;
    localparam logic [4:0] S_DIV1     = 5'd9;
    localparam logic [4:0] S_DIV_WAIT = 5'd10;
    localparam logic [4:0] S_WALK_RD  = 5'd11;
    localparam logic [4:0] S_WALK_CHK = 5'd12;
    localparam logic [4:0] S_HIT      = 5'd13;
    localparam logic [4:0] S_SQX      = 5'd14;
    localparam logic [4:0] S_SQY      = 5'd15;
    localparam logic [4:0] S_SUM      = 5'd16;
    localparam logic [4:0] S_PH_END   = 5'd17;
    localparam logic [4:0] S_OUT      = 5'd18;

    function automatic logic [19:0] sat20(input logic signed [PW-1:0] v);
        logic [19:0] r;
        if (v > PW'(524287)) begin
            r = 20'h7FFFF;
        end else if (v < -PW'(524288)) begin
            r = 20'h80000;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

    logic [4:0]  r_state, n_state;
    logic [AW-1:0] r_clr;

    logic [18:0] r_px, r_py;
    logic [23:0] r_view, r_half, r_astep;

    logic [9:0]  r_col;
    logic [23:0] r_ang;
    logic        r_trig;
    logic signed [15:0] r_sin, r_cos;
    logic        r_down, r_right;
    logic        r_ph;
    logic        r_dsel;
    logic signed [PW-1:0] r_u, r_w;
    logic [PW-1:0] r_step;
    logic [CW-1:0] r_cnt;
    logic [27:0] r_adx, r_ady;
    logic        r_dsat;
    logic [55:0] r_sqx;
    logic signed [PROD_W_T-1:0] r_prod;
    logic        r_have, r_vert;
    logic [31:0] r_best;
    logic [19:0] r_hx, r_hy;

    logic        r_ovalid;
    logic [9:0]  r_ocol;
    logic [19:0] r_ohx, r_ohy;
    logic [31:0] r_odist;
    logic        r_overt;

    // Shared multiplier operands.
    logic signed [MW-1:0] mul_a, mul_b;

    // Sine lookup.
    logic [23:0] ta;
    logic [22:0] sarg;
    logic [3:0]  si;
    logic [15:0] sd;
    logic [15:0] smag;
    logic signed [15:0] sval;

    // Walk terms.
    logic signed [15:0] t_n, t_o;
    logic [15:0] abs_tn;
    logic        upos, wpos;
    logic [18:0] pu, pw;
    logic signed [PW-1:0] u0, du, tu, tx, ty, hxc, hyc, dx, dy;
    logic signed [PW-1:0] mx, my, adx_f, ady_f;
    logic        in_map;
    logic [CW-1:0] limit;
    logic [56:0] sqsum;
    logic [31:0] dval;

    // Divider.
    logic                                 div_start;
    logic signed [grwi_pkg::NUM_W-1:0]    div_num;
    logic                                 div_done;
    logic signed [grwi_pkg::QUOT_W-1:0]   div_q;

    // Map RAM.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;

    logic in_acc;
    logic out_free;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        ta     = r_trig ? (r_ang + grwi_pkg::QUARTER_TURN) : r_ang;
        sarg   = ta[22] ? (23'(grwi_pkg::QUARTER_TURN) - {1'b0, ta[21:0]})
                        : {1'b0, ta[21:0]};
        si     = sarg[21:18];
        sd     = grwi_pkg::sine_rom({1'b0, si} + 5'd1) - grwi_pkg::sine_rom({1'b0, si});
        smag   = sarg[22] ? grwi_pkg::sine_rom(5'd16)
                          : grwi_pkg::sine_rom({1'b0, si})
                            + 16'((r_prod[31:0] + 32'd131072) >> 18);
        sval   = ta[23] ? -$signed(smag) : $signed(smag);
    end

    always_comb begin
        t_n    = r_ph ? r_cos : r_sin;
        t_o    = r_ph ? r_sin : r_cos;
        abs_tn = t_n[15] ? 16'(-t_n) : 16'(t_n);
        upos   = r_ph ? r_right : r_down;
        wpos   = r_ph ? r_down : r_right;
        pu     = r_ph ? r_px : r_py;
        pw     = r_ph ? r_py : r_px;
        u0     = $signed(PW'({pu[18:TS], {TS{1'b0}}}))
                 + (upos ? PW'(grwi_pkg::TILE_Q8) : PW'(0));
        du     = r_u - $signed(PW'(pu));
        // Looking up or left, the tested cell lies one pixel before the line.
        tu     = r_u - (upos ? PW'(0) : PW'(256));
        tx     = r_ph ? tu : r_w;
        ty     = r_ph ? r_w : tu;
        mx     = tx >>> TS;
        my     = ty >>> TS;
        in_map = !mx[PW-1] && (mx < PW'(grwi_pkg::MAP_COLUMNS))
                 && !my[PW-1] && (my < PW'(grwi_pkg::MAP_LINES));
        limit  = r_ph ? CW'(grwi_pkg::MAP_COLUMNS + 2) : CW'(grwi_pkg::MAP_LINES + 2);
        hxc    = r_ph ? r_u : r_w;
        hyc    = r_ph ? r_w : r_u;
        dx     = hxc - $signed(PW'(r_px));
        dy     = hyc - $signed(PW'(r_py));
        adx_f  = dx[PW-1] ? -dx : dx;
        ady_f  = dy[PW-1] ? -dy : dy;
        sqsum  = {1'b0, r_sqx} + {1'b0, r_prod[55:0]};
        dval   = (r_dsat || (|sqsum[56:40])) ? 32'hFFFF_FFFF : sqsum[39:8];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_ANG_MUL: begin
                mul_a = $signed(MW'(r_astep));
                mul_b = $signed(MW'(r_col));
            end
            S_SIN_MUL: begin
                mul_a = $signed(MW'(sd));
                mul_b = $signed(MW'(sarg[17:0]));
            end
            S_PH_MUL: begin
                mul_a = du[MW-1:0];
                mul_b = MW'(t_o);
            end
            S_SQX: begin
                mul_a = $signed(MW'(r_adx));
                mul_b = $signed(MW'(r_adx));
            end
            S_SQY: begin
                mul_a = $signed(MW'(r_ady));
                mul_b = $signed(MW'(r_ady));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = (r_state == S_DIV0) || (r_state == S_DIV1);
        div_num   = (r_state == S_DIV1)
                    ? $signed(grwi_pkg::NUM_W'(t_o) <<< TS)
                    : r_prod[grwi_pkg::NUM_W-1:0];
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = {my[grwi_pkg::ROW_W-1:0], mx[grwi_pkg::COL_W-1:0]};
        if (r_state == S_CLEAR) begin
            ram_we   = 1'b1;
            ram_addr = r_clr;
        end else if (in_acc && i_action == grwi_pkg::ACT_WRITE_CELL) begin
            ram_we    = 1'b1;
            ram_addr  = {i_cell_row, i_cell_col};
            ram_wdata = i_cell_wall;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == AW'(grwi_pkg::MAP_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:     if (in_acc && i_action == grwi_pkg::ACT_CAST) n_state = S_ANG_MUL;
            S_ANG_MUL:  n_state = S_ANG;
            S_ANG:      n_state = S_SIN_MUL;
            S_SIN_MUL:  n_state = S_SIN_FIN;
            S_SIN_FIN:  n_state = r_trig ? S_PH_START : S_SIN_MUL;
            S_PH_START: n_state = (abs_tn < 16'(grwi_pkg::MIN_TRIG)) ? S_PH_END : S_PH_MUL;
            S_PH_MUL:   n_state = S_DIV0;
            S_DIV0:     n_state = S_DIV_WAIT;
            S_DIV1:     n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) n_state = r_dsel ? S_WALK_RD : S_DIV1;
            S_WALK_RD:  n_state = in_map ? S_WALK_CHK : S_HIT;
            S_WALK_CHK: begin
                if (ram_rdata || (r_cnt + CW'(1) == limit)) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_HIT:      n_state = S_SQX;
            S_SQX:      n_state = S_SQY;
            S_SQY:      n_state = S_SUM;
            S_SUM:      n_state = S_PH_END;
            S_PH_END:   n_state = r_ph ? S_OUT : S_PH_START;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_px     <= 19'd163840;
            r_py     <= 19'd106496;
            r_view   <= 24'd4194304;
            r_half   <= 24'd1398101;
            r_astep  <= 24'd2913;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    grwi_pkg::CFG_PLAYER_X:   r_px    <= i_cfg_data[18:0];
                    grwi_pkg::CFG_PLAYER_Y:   r_py    <= i_cfg_data[18:0];
                    grwi_pkg::CFG_VIEW_ANGLE: r_view  <= i_cfg_data;
                    grwi_pkg::CFG_HALF_FOV:   r_half  <= i_cfg_data;
                    grwi_pkg::CFG_ANGLE_STEP: r_astep <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_col  <= i_ray_column;
                r_trig <= 1'b0;
                r_ph   <= 1'b0;
                r_have <= 1'b0;
                r_vert <= 1'b0;
                r_best <= '0;
                r_hx   <= {1'b0, r_px};
                r_hy   <= {1'b0, r_py};
            end
            S_ANG: begin
                r_ang <= r_view - r_half + r_prod[23:0];
            end
            S_SIN_FIN: begin
                if (r_trig) begin
                    r_cos <= sval;
                end else begin
                    r_sin <= sval;
                end
                r_trig  <= 1'b1;
                r_down  <= !r_ang[23] && (r_ang != 24'd0);
                r_right <= (r_ang[23:22] == 2'd0)
                           || (r_ang[23:22] == 2'd3 && r_ang[21:0] != 22'd0);
            end
            S_PH_START: begin
                r_u    <= u0;
                r_dsel <= 1'b0;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    if (r_dsel) begin
                        r_step <= div_q[QUOT_W_T-1] ? PW'(-div_q) : PW'(div_q);
                        r_cnt  <= '0;
                    end else begin
                        r_w    <= $signed(PW'(pw)) + PW'(div_q);
                        r_dsel <= 1'b1;
                    end
                end
            end
            S_WALK_CHK: begin
                if (!ram_rdata) begin
                    r_u   <= r_u + (upos ? PW'(grwi_pkg::TILE_Q8) : -PW'(grwi_pkg::TILE_Q8));
                    r_w   <= r_w + (wpos ? $signed(r_step) : -$signed(r_step));
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            S_HIT: begin
                r_adx  <= adx_f[27:0];
                r_ady  <= ady_f[27:0];
                r_dsat <= (|adx_f[PW-1:28]) || (|ady_f[PW-1:28]);
            end
            S_SQY: begin
                r_sqx <= r_prod[55:0];
            end
            S_SUM: begin
                if (!r_ph || !r_have || dval < r_best) begin
                    r_best <= dval;
                    r_hx   <= sat20(hxc);
                    r_hy   <= sat20(hyc);
                    r_vert <= r_ph;
                    r_have <= 1'b1;
                end
            end
            S_PH_END: begin
                r_ph <= 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    r_ocol  <= r_col;
                    r_ohx   <= r_hx;
                    r_ohy   <= r_hy;
                    r_odist <= r_best;
                    r_overt <= r_vert;
                end
            end
            default: ;
        endcase
    end

    grwi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (t_n),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    grwi_ram #(
        .DEPTH (grwi_pkg::MAP_DEPTH),
        .AW    (AW),
        .DW    (1)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_valid          = r_ovalid;
    assign o_ray_column_out = r_ocol;
    assign o_hit_x          = $signed(r_ohx);
    assign o_hit_y          = $signed(r_ohy);
    assign o_sq_distance    = r_odist;
    assign o_vertical_hit   = r_overt;

endmodule
